// ===== rtl/core/rsmv_pkg.sv =====
// rsmv_pkg: shared types and constants of the resampling stereo mixer voice
// used by rsmv_mul, rsmv_ring and resampling_stereo_mixer_voice; no dependencies
`default_nettype none

package rsmv_pkg;

    localparam int RING_FRAMES_DEF   = 256;
    localparam int FRACTION_BITS_DEF = 12;

    localparam int FRAME_W   = 32;
    localparam int SAMPLE_W  = 16;
    localparam int RING_W    = 2 * SAMPLE_W;
    localparam int MIX_W     = 32;
    localparam int GAIN_W    = 15;
    localparam int STEP_W    = 16;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int FILL_AHEAD = 3;

    localparam logic [STEP_W-1:0]  STEP_RESET   = 16'd4096;
    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 15'd4096;
    localparam logic [FRAME_W-1:0] LENGTH_RESET = 32'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 3'd0,
        MODE_TICK  = 3'd1,
        MODE_PLAY  = 3'd2,
        MODE_PAUSE = 3'd3,
        MODE_STOP  = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_RATE     = 3'd0,
        CFG_LEFT_GAIN     = 3'd1,
        CFG_RIGHT_GAIN    = 3'd2,
        CFG_MASTER_GAIN   = 3'd3,
        CFG_LENGTH_FRAMES = 3'd4,
        CFG_LOOP_ENABLE   = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PS_STOPPED = 2'd0,
        PS_PLAYING = 2'd1,
        PS_PAUSED  = 2'd2
    } play_state_t;

    typedef enum logic [2:0] {
        OP_IL = 3'd0,
        OP_IR = 3'd1,
        OP_GL = 3'd2,
        OP_GR = 3'd3,
        OP_ML = 3'd4,
        OP_MR = 3'd5
    } mul_op_t;

    typedef struct packed {
        logic    go;
        mul_op_t op;
    } mul_req_t;

    typedef struct packed {
        logic    done;
        mul_op_t op;
    } mul_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/resampling_stereo_mixer_voice.sv =====
// resampling_stereo_mixer_voice: one mixer voice, top level with sequencer
// depends on rsmv_pkg, rsmv_mul and rsmv_ring
//
// One voice of a stereo mixer. Load words fill a ring of RING_FRAMES stereo frames (a power of
// two), play/pause/stop words set the play state, and each tick word renders one output frame:
// linear interpolation at a (16-FRACTION_BITS).FRACTION_BITS step, left/right gains added to
// the incoming mix sums, then master gain with 16-bit saturation. All arithmetic goes through one
// shared 33x17 multiplier stepped by a small sequencer; the block takes one word at a time.
// Load, play, pause, stop and unknown words go straight to the result. A tick that is not
// playing, stops at the end mark or underruns only applies the master gain; at unit step it
// makes one ring read, and otherwise two through the single read port; it does up to six
// multiplies, one per cycle.
// The result register lets the next word in while a result waits.
`default_nettype none

module resampling_stereo_mixer_voice
    import rsmv_pkg::*;
#(
    parameter int RING_FRAMES   = RING_FRAMES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // sample_left, sample_right, mix_left_in, mix_right_in
    input  wire logic [95:0]           s_tdata,
    // mode
    input  wire logic [MODE_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // mix_left_out, mix_right_out, out_left, out_right
    output logic [95:0]                m_tdata,
    // fill_request, underrun, is_playing
    output logic [2:0]                 m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW    = $clog2(RING_FRAMES);
    localparam int POS_W = FRAME_W + FRACTION_BITS;
    localparam logic [STEP_W:0] UNIT_STEP = (STEP_W + 1)'(1) << FRACTION_BITS;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_CHECK = 12'b0000_0000_0010,
        S_UCHK  = 12'b0000_0000_0100,
        S_RDA   = 12'b0000_0000_1000,
        S_RDB   = 12'b0000_0001_0000,
        S_IR    = 12'b0000_0010_0000,
        S_GL    = 12'b0000_0100_0000,
        S_GR    = 12'b0000_1000_0000,
        S_ML    = 12'b0001_0000_0000,
        S_MR    = 12'b0010_0000_0000,
        S_SAT   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [STEP_W-1:0]  step_rate_reg;
    logic [GAIN_W-1:0]  left_gain_reg;
    logic [GAIN_W-1:0]  right_gain_reg;
    logic [GAIN_W-1:0]  master_gain_reg;
    logic [FRAME_W-1:0] length_reg;
    logic               loop_reg;

    logic [POS_W-1:0]   pos_reg;
    logic [FRAME_W-1:0] loaded_reg;
    logic [FRAME_W-1:0] end_reg;
    play_state_t        play_reg;

    logic [MIX_W-1:0]           mix_l_reg, mix_r_reg;
    logic [SAMPLE_W-1:0]        out_l_reg, out_r_reg;
    logic                       fill_reg, under_reg;
    logic signed [SAMPLE_W-1:0] a_l_reg, a_r_reg, b_r_reg;
    logic signed [SAMPLE_W-1:0] int_l_reg, int_r_reg;

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    logic [FRAME_W-1:0]       frame;
    logic [FRACTION_BITS-1:0] frac;
    logic                     fill_hit, end_hit, under_hit, unit_step, stop_now;
    logic                     in_accept, out_free;
    mode_t                    in_mode;

    logic                 wr_en, rd_en;
    logic [AW-1:0]        rd_addr;
    logic [RING_W-1:0]    rd_data;
    logic signed [SAMPLE_W-1:0] q_l, q_r;
    logic signed [SAMPLE_W:0]   diff_l, diff_r;

    mul_req_t                  mul_req;
    mul_rsp_t                  mul_rsp;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_q;

    function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [MUL_P_W-1:0] x);
        logic signed [MUL_P_W-1:0] hi;
        logic signed [MUL_P_W-1:0] lo;
        logic [SAMPLE_W-1:0]       r;
        hi = MUL_P_W'(SAMPLE_MAX);
        lo = MUL_P_W'(SAMPLE_MIN);
        if (x > hi) begin
            r = hi[SAMPLE_W-1:0];
        end else if (x < lo) begin
            r = lo[SAMPLE_W-1:0];
        end else begin
            r = x[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    assign frame     = pos_reg[FRACTION_BITS +: FRAME_W];
    assign frac      = pos_reg[FRACTION_BITS-1:0];
    assign fill_hit  = ({1'b0, frame} + (FRAME_W + 1)'(FILL_AHEAD)) >= {1'b0, loaded_reg};
    assign under_hit = ({1'b0, frame} + (FRAME_W + 1)'(1)) >= {1'b0, loaded_reg};
    assign end_hit   = frame >= end_reg;
    assign stop_now  = end_hit && !loop_reg;
    assign unit_step = {1'b0, step_rate_reg} == UNIT_STEP;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_mode   = mode_t'(s_tuser);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // frame ring
    assign wr_en   = in_accept && (in_mode == MODE_LOAD);
    assign rd_en   = ((state_reg == S_UCHK) && !under_hit) || ((state_reg == S_RDA) && !unit_step);
    assign rd_addr = (state_reg == S_RDA) ? frame[AW-1:0] + AW'(1) : frame[AW-1:0];
    assign q_l     = rd_data[SAMPLE_W-1:0];
    assign q_r     = rd_data[RING_W-1:SAMPLE_W];
    assign diff_l  = {q_l[SAMPLE_W-1], q_l} - {a_l_reg[SAMPLE_W-1], a_l_reg};
    assign diff_r  = {b_r_reg[SAMPLE_W-1], b_r_reg} - {a_r_reg[SAMPLE_W-1], a_r_reg};

    rsmv_ring #(
        .RING_FRAMES(RING_FRAMES)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (loaded_reg[AW-1:0]),
        .wr_data (s_tdata[RING_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // multiplier operand selection
    always_comb begin
        mul_req.go = 1'b1;
        mul_req.op = OP_ML;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            S_RDB: begin
                mul_req.op = OP_IL;
                mul_a      = MUL_A_W'(diff_l);
                mul_b      = $signed(MUL_B_W'(frac));
            end
            S_IR: begin
                mul_req.op = OP_IR;
                mul_a      = MUL_A_W'(diff_r);
                mul_b      = $signed(MUL_B_W'(frac));
            end
            S_GL: begin
                mul_req.op = OP_GL;
                mul_a      = MUL_A_W'(int_l_reg);
                mul_b      = $signed(MUL_B_W'(left_gain_reg));
            end
            S_GR: begin
                mul_req.op = OP_GR;
                mul_a      = MUL_A_W'(int_r_reg);
                mul_b      = $signed(MUL_B_W'(right_gain_reg));
            end
            S_ML: begin
                mul_req.op = OP_ML;
                mul_a      = MUL_A_W'($signed(mix_l_reg));
                mul_b      = $signed(MUL_B_W'(master_gain_reg));
            end
            S_MR: begin
                mul_req.op = OP_MR;
                mul_a      = MUL_A_W'($signed(mix_r_reg));
                mul_b      = $signed(MUL_B_W'(master_gain_reg));
            end
            default: begin
                mul_req.go = 1'b0;
            end
        endcase
    end

    rsmv_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .rsp     (mul_rsp),
        .q       (mul_q)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (in_mode != MODE_TICK) begin
                        state_next = S_DONE;
                    end else if (play_reg == PS_PLAYING) begin
                        state_next = S_CHECK;
                    end else begin
                        state_next = S_ML;
                    end
                end
            end
            S_CHECK: state_next = stop_now ? S_ML : S_UCHK;
            S_UCHK:  state_next = under_hit ? S_ML : S_RDA;
            S_RDA:   state_next = unit_step ? S_GL : S_RDB;
            S_RDB:   state_next = S_IR;
            S_IR:    state_next = S_GL;
            S_GL:    state_next = S_GR;
            S_GR:    state_next = S_ML;
            S_ML:    state_next = S_MR;
            S_MR:    state_next = S_SAT;
            S_SAT:   state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            step_rate_reg   <= STEP_RESET;
            left_gain_reg   <= GAIN_RESET;
            right_gain_reg  <= GAIN_RESET;
            master_gain_reg <= GAIN_RESET;
            length_reg      <= LENGTH_RESET;
            loop_reg        <= 1'b0;
            pos_reg         <= '0;
            loaded_reg      <= '0;
            end_reg         <= '0;
            play_reg        <= PS_STOPPED;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_STEP_RATE:     step_rate_reg   <= cfg_data[STEP_W-1:0];
                    CFG_LEFT_GAIN:     left_gain_reg   <= cfg_data[GAIN_W-1:0];
                    CFG_RIGHT_GAIN:    right_gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_MASTER_GAIN:   master_gain_reg <= cfg_data[GAIN_W-1:0];
                    CFG_LENGTH_FRAMES: length_reg      <= cfg_data[FRAME_W-1:0];
                    CFG_LOOP_ENABLE:   loop_reg        <= cfg_data[0];
                    default: ;
                endcase
            end

            if (in_accept) begin
                unique case (in_mode)
                    MODE_LOAD:  loaded_reg <= loaded_reg + FRAME_W'(1);
                    MODE_PLAY:  play_reg   <= PS_PLAYING;
                    MODE_PAUSE: play_reg   <= PS_PAUSED;
                    MODE_STOP: begin
                        play_reg   <= PS_STOPPED;
                        pos_reg    <= '0;
                        end_reg    <= length_reg;
                        loaded_reg <= '0;
                    end
                    default: ;
                endcase
            end

            if (state_reg == S_CHECK && end_hit) begin
                end_reg <= frame + length_reg;
                if (!loop_reg) begin
                    play_reg <= PS_STOPPED;
                end
            end

            if (state_reg == S_GR) begin
                pos_reg <= pos_reg + POS_W'(step_rate_reg);
            end

            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            fill_reg  <= 1'b0;
            under_reg <= 1'b0;
            if (in_mode == MODE_TICK) begin
                mix_l_reg <= s_tdata[63:32];
                mix_r_reg <= s_tdata[95:64];
            end else begin
                mix_l_reg <= '0;
                mix_r_reg <= '0;
                out_l_reg <= '0;
                out_r_reg <= '0;
            end
        end

        if (state_reg == S_CHECK) begin
            fill_reg <= fill_hit;
        end
        if (state_reg == S_UCHK && under_hit) begin
            under_reg <= 1'b1;
        end

        if (state_reg == S_RDA) begin
            if (unit_step) begin
                int_l_reg <= q_l;
                int_r_reg <= q_r;
            end else begin
                a_l_reg <= q_l;
                a_r_reg <= q_r;
            end
        end
        if (state_reg == S_RDB) begin
            b_r_reg <= q_r;
        end

        if (mul_rsp.done) begin
            unique case (mul_rsp.op)
                OP_IL:   int_l_reg <= a_l_reg + mul_q[SAMPLE_W-1:0];
                OP_IR:   int_r_reg <= a_r_reg + mul_q[SAMPLE_W-1:0];
                OP_GL:   mix_l_reg <= mix_l_reg + mul_q[MIX_W-1:0];
                OP_GR:   mix_r_reg <= mix_r_reg + mul_q[MIX_W-1:0];
                OP_ML:   out_l_reg <= sat16(mul_q);
                OP_MR:   out_r_reg <= sat16(mul_q);
                default: ;
            endcase
        end

        if (state_reg == S_DONE && out_free) begin
            m_tdata_reg <= {out_r_reg, out_l_reg, mix_r_reg, mix_l_reg};
            m_tuser_reg <= {play_reg == PS_PLAYING, under_reg, fill_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // one word at a time through the sequencer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("word accepted while sequencer busy");

    a_mul_in_order: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == S_IR || state_reg == S_GL || state_reg == S_GR ||
                          state_reg == S_ML || state_reg == S_MR || state_reg == S_SAT))
        else $error("multiplier result outside multiply sequence");

    a_under_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg[1]) |-> (m_tuser_reg[2] && m_tuser_reg[0]))
        else $error("underrun without playing and fill request");

    a_pos_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> $stable(pos_reg))
        else $error("position moved outside tick sequence");

endmodule

`default_nettype wire

// ===== rtl/core/rsmv_mul.sv =====
// rsmv_mul: shared signed multiplier with registered product and floor shift
// the operation tag travels with the product; depends on rsmv_pkg
`default_nettype none

module rsmv_mul
    import rsmv_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mul_req_t                  req,
    input  wire logic signed [MUL_A_W-1:0] op_a,
    input  wire logic signed [MUL_B_W-1:0] op_b,
    output mul_rsp_t                       rsp,
    output logic signed [MUL_P_W-1:0]      q
);

    logic signed [MUL_P_W-1:0] prod;
    mul_rsp_t                  rsp_reg;
    logic signed [MUL_P_W-1:0] q_reg;

    assign prod = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_reg.done <= 1'b0;
            rsp_reg.op   <= OP_ML;
        end else begin
            rsp_reg.done <= req.go;
            rsp_reg.op   <= req.op;
        end
    end

    // floor shift of the product
    always_ff @(posedge aclk) begin
        q_reg <= prod >>> FRACTION_BITS;
    end

    assign rsp = rsp_reg;
    assign q   = q_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rsmv_ring.sv =====
// rsmv_ring: frame ring, one write port and one registered read port
// depends on rsmv_pkg
`default_nettype none

module rsmv_ring
    import rsmv_pkg::*;
#(
    parameter int RING_FRAMES = RING_FRAMES_DEF,
    localparam int AW = $clog2(RING_FRAMES)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [RING_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic [RING_W-1:0]      rd_data
);

    logic [RING_W-1:0] ring_mem [RING_FRAMES];
    logic [RING_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
